FILE: rtl/core/centered_window_average_macros.svh
//------------------------------------------------------------------------------
// Assertion macros for the centered window average block
// Immediate-cycle and next-cycle implication checks, disabled in reset.
//------------------------------------------------------------------------------
`ifndef CENTERED_WINDOW_AVERAGE_MACROS_SVH
`define CENTERED_WINDOW_AVERAGE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CWA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CWA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/cwa_pkg.sv
//------------------------------------------------------------------------------
// cwa_pkg
// Shared constants for the centered window average block.
//------------------------------------------------------------------------------
`default_nettype none

package cwa_pkg;

  localparam int unsigned SampleW           = 16;
  localparam int unsigned HalfWindowDefault = 5;

endpackage

`default_nettype wire

FILE: rtl/core/cwa_in_if.sv
//------------------------------------------------------------------------------
// cwa_in_if
// Sample channel: valid/ready handshake carrying one sample per beat.
//------------------------------------------------------------------------------
`default_nettype none

interface cwa_in_if;

  logic                         valid;
  logic                         ready;
  logic [cwa_pkg::SampleW-1:0]  sample;
  logic                         end_of_vector;

  modport source (output valid, output sample, output end_of_vector, input ready);
  modport sink   (input valid, input sample, input end_of_vector, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/cwa_out_if.sv
//------------------------------------------------------------------------------
// cwa_out_if
// Result channel: valid/ready handshake carrying one average per beat.
//------------------------------------------------------------------------------
`default_nettype none

interface cwa_out_if;

  logic                         valid;
  logic                         ready;
  logic [cwa_pkg::SampleW-1:0]  average;
  logic                         final_result;

  modport source (output valid, output average, output final_result, input ready);
  modport sink   (input valid, input average, input final_result, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/cwa_cell.sv
//------------------------------------------------------------------------------
// cwa_cell
// One window cell: holds a sample and takes its neighbour's on each shift.
//------------------------------------------------------------------------------
`default_nettype none

module cwa_cell #(
  parameter int unsigned DataW = cwa_pkg::SampleW
) (
  input  wire logic             clk_i,
  input  wire logic             shift_i,
  input  wire logic [DataW-1:0] data_i,
  output      logic [DataW-1:0] data_o
);

  logic [DataW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/cwa_div.sv
//------------------------------------------------------------------------------
// cwa_div
// Restoring divider, one quotient bit per cycle, pulses done when finished.
//------------------------------------------------------------------------------
`default_nettype none

module cwa_div #(
  parameter int unsigned NumW = 20,
  parameter int unsigned DenW = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output      logic            done_o,
  output      logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q;
  logic [DenW:0]   rem_sh;
  logic [DenW:0]   rem_sub;
  logic            fits;

  assign rem_sh  = {rem_q, num_q[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NumW-2:0], fits};
      rem_q <= fits ? rem_sub[DenW-1:0] : rem_sh[DenW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

FILE: rtl/core/centered_window_average.sv
// Flow per result: a ring pass over the window cells sums the neighbours,
//   then the bit-serial divider divides by their count, then the result is offered.
// Throughput: one sample at a time; the end-of-vector beat yields up to
//   HALF_WINDOW + 1 results, each taking the same ring pass and division.
// The ring rotation and the bit-serial divider set the pace; no neighbours skips the divider.
// Reset: asynchronous, active low; counters and control clear, window cells keep data.
//------------------------------------------------------------------------------
// centered_window_average
// Mean of up to HALF_WINDOW neighbours on each side of each sample, centre excluded.
//------------------------------------------------------------------------------
`default_nettype none

module centered_window_average #(
  parameter int unsigned HALF_WINDOW = cwa_pkg::HalfWindowDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cwa_in_if.sink     in_i,
  cwa_out_if.source  out_o
);

  localparam int unsigned SampleW = cwa_pkg::SampleW;
  localparam int unsigned Depth   = 2 * HALF_WINDOW + 1;
  localparam int unsigned AgeW    = $clog2(Depth);
  localparam int unsigned CntW    = $clog2(HALF_WINDOW + 2);
  localparam int unsigned SumW    = SampleW + AgeW;

  localparam logic [CntW-1:0] SeenFull = CntW'(HALF_WINDOW + 1);
  localparam logic [CntW-1:0] EmitFull = CntW'(HALF_WINDOW);
  localparam logic [AgeW-1:0] LastAge  = AgeW'(Depth - 1);
  localparam logic [AgeW-1:0] HalfAge  = AgeW'(HALF_WINDOW);

  typedef enum logic [1:0] {
    StIdle,
    StSum,
    StDiv,
    StOut
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   seen_q, seen_d;
  logic [CntW-1:0]   emitted_q, emitted_d;
  logic [AgeW-1:0]   target_q, target_d;
  logic [AgeW-1:0]   right_q, right_d;
  logic [AgeW-1:0]   step_q, step_d;
  logic              flush_q, flush_d;
  logic [SumW-1:0]   acc_q, acc_d;
  logic [SampleW-1:0] avg_q, avg_d;

  logic [SampleW-1:0] cell_q [Depth];
  logic [SampleW-1:0] cell_d [Depth];
  logic               shift_en;
  logic               ring;

  logic               in_acc;
  logic               out_acc;
  logic [AgeW:0]      age_x, tgt_x, left_x, right_x;
  logic               take;
  logic [SumW-1:0]    acc_sum;
  logic [AgeW-1:0]    count;
  logic [CntW-1:0]    seen_inc;
  logic [CntW-1:0]    seen_m1;
  logic [CntW-1:0]    emitted_inc;
  logic               div_start;
  logic               div_done;
  logic [SumW-1:0]    div_quot;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign ring    = (state_q == StSum);
  assign shift_en = in_acc || ring;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cell_d[g] = ring ? cell_q[Depth-1] : in_i.sample;
    end else begin : g_body
      assign cell_d[g] = cell_q[g-1];
    end
    cwa_cell #(
      .DataW (SampleW)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_en),
      .data_i  (cell_d[g]),
      .data_o  (cell_q[g])
    );
  end

  assign age_x   = {1'b0, step_q};
  assign tgt_x   = {1'b0, target_q};
  assign left_x  = (AgeW + 1)'(emitted_q);
  assign right_x = {1'b0, right_q};
  assign take    = ((age_x > tgt_x) && (age_x <= tgt_x + left_x)) ||
                   ((age_x < tgt_x) && (age_x + right_x >= tgt_x));
  assign acc_sum = acc_q + (take ? SumW'(cell_q[Depth-1]) : '0);
  assign count   = AgeW'(emitted_q) + right_q;

  assign seen_inc    = (seen_q == SeenFull) ? seen_q : seen_q + 1'b1;
  assign seen_m1     = seen_inc - 1'b1;
  assign emitted_inc = (emitted_q == EmitFull) ? emitted_q : emitted_q + 1'b1;

  assign div_start = ring && (step_q == '0) && (count != '0);

  cwa_div #(
    .NumW (SumW),
    .DenW (AgeW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_sum),
    .den_i   (count),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d   = state_q;
    seen_d    = seen_q;
    emitted_d = emitted_q;
    target_d  = target_q;
    right_d   = right_q;
    step_d    = step_q;
    flush_d   = flush_q;
    acc_d     = acc_q;
    avg_d     = avg_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          seen_d = seen_inc;
          if (in_i.end_of_vector) begin
            flush_d  = 1'b1;
            target_d = AgeW'(seen_m1);
            right_d  = AgeW'(seen_m1);
            step_d   = LastAge;
            acc_d    = '0;
            state_d  = StSum;
          end else if (seen_inc == SeenFull) begin
            flush_d  = 1'b0;
            target_d = HalfAge;
            right_d  = HalfAge;
            step_d   = LastAge;
            acc_d    = '0;
            state_d  = StSum;
          end
        end
      end
      StSum: begin
        acc_d  = acc_sum;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          if (count == '0) begin
            avg_d   = '0;
            state_d = StOut;
          end else begin
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_done) begin
          avg_d   = div_quot[SampleW-1:0];
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_acc) begin
          emitted_d = emitted_inc;
          if (flush_q && (target_q != '0)) begin
            target_d = target_q - 1'b1;
            right_d  = target_q - 1'b1;
            step_d   = LastAge;
            acc_d    = '0;
            state_d  = StSum;
          end else if (flush_q) begin
            seen_d    = '0;
            emitted_d = '0;
            flush_d   = 1'b0;
            state_d   = StIdle;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      seen_q    <= '0;
      emitted_q <= '0;
      target_q  <= '0;
      right_q   <= '0;
      step_q    <= '0;
      flush_q   <= 1'b0;
      acc_q     <= '0;
      avg_q     <= '0;
    end else begin
      state_q   <= state_d;
      seen_q    <= seen_d;
      emitted_q <= emitted_d;
      target_q  <= target_d;
      right_q   <= right_d;
      step_q    <= step_d;
      flush_q   <= flush_d;
      acc_q     <= acc_d;
      avg_q     <= avg_d;
    end
  end

  assign in_i.ready         = (state_q == StIdle);
  assign out_o.valid        = (state_q == StOut);
  assign out_o.average      = avg_q;
  assign out_o.final_result = flush_q && (target_q == '0);

endmodule

`default_nettype wire

FILE: rtl/core/cwa_checker.sv
//------------------------------------------------------------------------------
// cwa_checker
// Port-level checks on the centered window average block, bound to the top.
//------------------------------------------------------------------------------
`default_nettype none

`include "centered_window_average_macros.svh"

module cwa_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [cwa_pkg::SampleW-1:0] out_average_i,
  input wire logic                        out_final_i
);

  `CWA_ASSERT_NEXT(a_sample_no_result, clk_i, rst_ni, in_valid_i && in_ready_i, !out_valid_i, "result offered in the cycle after a sample beat")

  `CWA_ASSERT_NOW(a_result_blocks_input, clk_i, rst_ni, out_valid_i, !in_ready_i, "input ready while a result is pending")

  `CWA_ASSERT_NEXT(a_final_frees_input, clk_i, rst_ni, out_valid_i && out_ready_i && out_final_i, in_ready_i && !out_valid_i, "block not idle after the final result beat")

  `CWA_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_average_i) && $stable(out_final_i), "stalled result beat changed")

endmodule

bind centered_window_average cwa_checker u_cwa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_average_i (out_o.average),
  .out_final_i   (out_o.final_result)
);

`default_nettype wire
